// ===== src/cdh_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package cdh_pkg;

    localparam int DEPTH_BITS_DEF = 24;
    localparam int CAP_W          = 24;
    localparam logic [CAP_W-1:0] CAP_RESET = 24'd250;

    localparam int DELTA_W   = 16;
    localparam int CODE_W    = 4;
    localparam int CNT_W     = 64;
    localparam int INC_W     = 32;

    localparam int NUM_COUNTERS = 13;
    localparam int NUM_THRESH   = 8;
    localparam int IDX_W        = 4;

    localparam logic [IDX_W-1:0] IDX_REF      = 4'd0;
    localparam logic [IDX_W-1:0] IDX_NBASE    = 4'd1;
    localparam logic [IDX_W-1:0] IDX_COVERED  = 4'd2;
    localparam logic [IDX_W-1:0] IDX_EXCLUDED = 4'd3;
    localparam logic [IDX_W-1:0] IDX_CAPPED   = 4'd4;
    localparam logic [IDX_W-1:0] IDX_THRESH0  = 4'd5;
    localparam logic [IDX_W-1:0] IDX_LAST     = 4'd12;

    localparam logic [CODE_W-1:0] N_CODE = 4'd15;

    localparam logic [INC_W-1:0] THRESH_LEVEL [NUM_THRESH] = '{
        32'd1, 32'd5, 32'd10, 32'd15, 32'd20, 32'd25, 32'd30, 32'd40
    };

    typedef struct packed {
        logic                  valid;
        logic                  report;
        logic                  is_n;
        logic [INC_W-1:0]      cov_inc;
        logic [INC_W-1:0]      exc_inc;
        logic [INC_W-1:0]      cap_inc;
        logic [NUM_THRESH-1:0] thr_hit;
    } t_incr;

endpackage

`default_nettype wire

// ===== src/cdh_counters.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cdh_counters (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire cdh_pkg::t_incr            i_incr,
    input  wire logic                      i_out_stall,
    output logic                           o_out_valid,
    output logic [cdh_pkg::IDX_W-1:0]      o_counter_index,
    output logic [cdh_pkg::CNT_W-1:0]      o_counter_value,
    output logic                           o_last_counter,
    output logic                           o_emitting
);
    import cdh_pkg::*;

    logic [CNT_W-1:0] r_cnt [NUM_COUNTERS];
    logic [CNT_W-1:0] n_cnt [NUM_COUNTERS];
    logic             r_emitting;
    logic [IDX_W-1:0] r_emit_idx;
    logic             r_out_valid;
    logic [IDX_W-1:0] r_out_index;
    logic [CNT_W-1:0] r_out_value;
    logic             r_out_last;
    logic             w_pos;
    logic             w_load;

    assign w_pos  = i_incr.valid && !i_incr.report;
    assign w_load = r_emitting && (!r_out_valid || !i_out_stall);

    always_comb begin
        for (int k = 0; k < NUM_COUNTERS; k++) begin
            n_cnt[k] = r_cnt[k];
        end
        if (w_pos) begin
            n_cnt[IDX_REF]      = r_cnt[IDX_REF] + 64'd1;
            n_cnt[IDX_NBASE]    = r_cnt[IDX_NBASE] + CNT_W'(i_incr.is_n);
            n_cnt[IDX_COVERED]  = r_cnt[IDX_COVERED] + CNT_W'(i_incr.cov_inc);
            n_cnt[IDX_EXCLUDED] = r_cnt[IDX_EXCLUDED] + CNT_W'(i_incr.exc_inc);
            n_cnt[IDX_CAPPED]   = r_cnt[IDX_CAPPED] + CNT_W'(i_incr.cap_inc);
            for (int t = 0; t < NUM_THRESH; t++) begin
                n_cnt[int'(IDX_THRESH0) + t] = r_cnt[int'(IDX_THRESH0) + t]
                                               + CNT_W'(i_incr.thr_hit[t]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_COUNTERS; k++) begin
                r_cnt[k] <= '0;
            end
        end else begin
            for (int k = 0; k < NUM_COUNTERS; k++) begin
                r_cnt[k] <= n_cnt[k];
            end
        end
    end

    // walk the bank one counter per taken slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_emitting  <= 1'b0;
            r_emit_idx  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_incr.valid && i_incr.report) begin
                r_emitting <= 1'b1;
                r_emit_idx <= IDX_REF;
            end else if (w_load) begin
                r_emit_idx <= r_emit_idx + 4'd1;
                if (r_emit_idx == IDX_LAST) begin
                    r_emitting <= 1'b0;
                end
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_index <= r_emit_idx;
            r_out_value <= r_cnt[r_emit_idx];
            r_out_last  <= (r_emit_idx == IDX_LAST);
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_counter_index = r_out_index;
    assign o_counter_value = r_out_value;
    assign o_last_counter  = r_out_last;
    assign o_emitting      = r_emitting;

endmodule

`default_nettype wire

// ===== src/coverage_depth_histogram_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake                   Payload
// in        sink       i_in_valid / o_in_stall     i_depth_delta, i_base_code,
//                                                  i_contig_end, i_report
// out       source     o_out_valid / i_out_stall   o_counter_index, o_counter_value,
//                                                  o_last_counter
// cfg       sink       i_cfg_we                    i_cfg_wdata (coverage cap)
//
// Position requests are taken one per cycle while no report is in flight; counters
// update through the depth, increment and counter registers behind the input register.
// A report request holds stall while it drains the pipeline and loads all 13 counters
// into the output register, so the next request is taken only once the last counter
// is loaded, and later still while a loaded counter waits on output stall.
// Reset is synchronous, active low: depth and counters zero, cap 250.

module coverage_depth_histogram_core #(
    parameter int DEPTH_BITS = cdh_pkg::DEPTH_BITS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire logic signed [cdh_pkg::DELTA_W-1:0] i_depth_delta,
    input  wire logic [cdh_pkg::CODE_W-1:0]     i_base_code,
    input  wire logic                           i_contig_end,
    input  wire logic                           i_report,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output logic [cdh_pkg::IDX_W-1:0]           o_counter_index,
    output logic [cdh_pkg::CNT_W-1:0]           o_counter_value,
    output logic                                o_last_counter,
    input  wire logic                           i_cfg_we,
    input  wire logic [cdh_pkg::CAP_W-1:0]      i_cfg_wdata
);
    import cdh_pkg::*;

    localparam int SUM_W = ((DEPTH_BITS > DELTA_W) ? DEPTH_BITS : DELTA_W) + 2;

    logic [CAP_W-1:0]         r_cap;

    logic                     r_s1_valid;
    logic                     r_s1_report;
    logic signed [DELTA_W-1:0] r_s1_delta;
    logic                     r_s1_is_n;
    logic                     r_s1_last;

    logic [DEPTH_BITS-1:0]    r_depth;
    logic [DEPTH_BITS-1:0]    n_depth;
    logic signed [SUM_W-1:0]  w_sum;
    logic [DEPTH_BITS-1:0]    w_pos_depth;

    logic                     r_s2_valid;
    logic                     r_s2_report;
    logic                     r_s2_is_n;
    logic [DEPTH_BITS-1:0]    r_s2_depth;

    t_incr                    n_s3;
    t_incr                    r_s3;
    logic [INC_W-1:0]         w_d32;
    logic [INC_W-1:0]         w_c32;
    logic [INC_W-1:0]         w_over;
    logic                     w_above;

    logic                     w_accept;
    logic                     w_emitting;
    logic                     w_busy;

    assign w_busy     = (r_s1_valid && r_s1_report) || (r_s2_valid && r_s2_report)
                        || (r_s3.valid && r_s3.report) || w_emitting;
    assign o_in_stall = w_busy;
    assign w_accept   = i_in_valid && !w_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_RESET;
        end else if (i_cfg_we) begin
            r_cap <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_report <= i_report;
            r_s1_delta  <= i_depth_delta;
            r_s1_is_n   <= (i_base_code == N_CODE);
            r_s1_last   <= i_contig_end;
        end
    end

    // running depth with saturation at zero and full scale, cleared after a contig end
    always_comb begin
        w_sum = SUM_W'($signed({1'b0, r_depth})) + SUM_W'(r_s1_delta);
        if (w_sum[SUM_W-1]) begin
            w_pos_depth = '0;
        end else if (w_sum[SUM_W-2:DEPTH_BITS] != '0) begin
            w_pos_depth = '1;
        end else begin
            w_pos_depth = w_sum[DEPTH_BITS-1:0];
        end
        n_depth = r_depth;
        if (r_s1_valid && !r_s1_report) begin
            n_depth = r_s1_last ? '0 : w_pos_depth;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth    <= '0;
            r_s2_valid <= 1'b0;
        end else begin
            r_depth    <= n_depth;
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_report <= r_s1_report;
        r_s2_is_n   <= r_s1_is_n;
        r_s2_depth  <= w_pos_depth;
    end

    // split depth into covered, excluded and capped amounts and threshold hits
    always_comb begin
        w_d32   = INC_W'(r_s2_depth);
        w_c32   = INC_W'(r_cap);
        w_above = (w_d32 > w_c32);
        w_over  = w_d32 - w_c32;
        n_s3.valid  = r_s2_valid;
        n_s3.report = r_s2_report;
        n_s3.is_n   = r_s2_is_n;
        if (r_s2_is_n) begin
            n_s3.cov_inc = '0;
            n_s3.exc_inc = w_d32;
            n_s3.cap_inc = '0;
            n_s3.thr_hit = '0;
        end else begin
            n_s3.cov_inc = w_above ? w_c32 : w_d32;
            n_s3.exc_inc = w_above ? w_over : '0;
            n_s3.cap_inc = w_above ? w_over : '0;
            for (int t = 0; t < NUM_THRESH; t++) begin
                n_s3.thr_hit[t] = (w_d32 >= THRESH_LEVEL[t]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3 <= '0;
        end else begin
            r_s3 <= n_s3;
        end
    end

    cdh_counters u_counters (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_incr          (r_s3),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_counter_index (o_counter_index),
        .o_counter_value (o_counter_value),
        .o_last_counter  (o_last_counter),
        .o_emitting      (w_emitting)
    );

endmodule

`default_nettype wire

// ===== test/coverage_depth_histogram_core_test.sv =====
`timescale 1ns / 1ps

module coverage_depth_histogram_core_test;
    import cdh_pkg::*;

    localparam int SETTLE_CYCLES = 12;
    localparam int TAIL_CYCLES   = 24;
    localparam int QUIET_LIMIT   = 4000;
    localparam int RANDOM_ITEMS  = 16;
    localparam int CLIMB_ITEMS   = 32;

    typedef struct {
        logic signed [DELTA_W-1:0] delta;
        logic [CODE_W-1:0]         code;
        logic                      contig_end;
        logic                      report;
    } t_position_req;

    typedef struct {
        logic [IDX_W-1:0] index;
        logic [CNT_W-1:0] value;
        logic             last;
    } t_counter_rec;

    class depth_tally;
        logic [CAP_W-1:0]          cap;
        logic [DEPTH_BITS_DEF-1:0] depth;
        logic [CNT_W-1:0]          tally [NUM_COUNTERS];
        t_counter_rec              due_counters [$];
        int                        errors;

        function new();
            cap    = CAP_RESET;
            depth  = '0;
            errors = 0;
            foreach (tally[k]) tally[k] = '0;
        endfunction

        function int pending();
            return due_counters.size();
        endfunction

        function void note_request(t_position_req r);
            t_counter_rec     rec;
            longint           nxt;
            longint           top;
            logic [CNT_W-1:0] d64;
            logic [CNT_W-1:0] c64;
            if (r.report) begin
                for (int k = 0; k < NUM_COUNTERS; k++) begin
                    rec.index = IDX_W'(k);
                    rec.value = tally[k];
                    rec.last  = (IDX_W'(k) == IDX_LAST);
                    due_counters.push_back(rec);
                end
                return;
            end
            top = (longint'(1) << DEPTH_BITS_DEF) - 1;
            nxt = longint'(depth) + longint'(r.delta);
            if (nxt < 0) nxt = 0;
            if (nxt > top) nxt = top;
            depth = nxt[DEPTH_BITS_DEF-1:0];
            d64 = CNT_W'(depth);
            c64 = CNT_W'(cap);
            tally[IDX_REF] += 1;
            if (r.code == N_CODE) begin
                tally[IDX_NBASE]    += 1;
                tally[IDX_EXCLUDED] += d64;
            end else begin
                if (d64 > c64) begin
                    tally[IDX_COVERED]  += c64;
                    tally[IDX_EXCLUDED] += d64 - c64;
                    tally[IDX_CAPPED]   += d64 - c64;
                end else begin
                    tally[IDX_COVERED] += d64;
                end
                for (int t = 0; t < NUM_THRESH; t++) begin
                    if (32'(depth) >= THRESH_LEVEL[t]) tally[IDX_THRESH0 + t] += 1;
                end
            end
            if (r.contig_end) depth = '0;
        endfunction

        function void check_counter(logic [IDX_W-1:0] index, logic [CNT_W-1:0] value,
                                    logic last);
            t_counter_rec want;
            if (due_counters.size() == 0) begin
                $display("%0t: unexpected counter index %0d value %h", $time, index, value);
                errors++;
                return;
            end
            want = due_counters.pop_front();
            if (index !== want.index) begin
                $display("%0t: counter_index expected %0d actual %0d",
                         $time, want.index, index);
                errors++;
            end
            if (value !== want.value) begin
                $display("%0t: counter_value [%0d] expected %h actual %h",
                         $time, want.index, want.value, value);
                errors++;
            end
            if (last !== want.last) begin
                $display("%0t: last_counter [%0d] expected %b actual %b",
                         $time, want.index, want.last, last);
                errors++;
            end
        endfunction
    endclass

    logic                      i_clk = 1'b0;
    logic                      i_rst_n;
    logic                      i_in_valid;
    logic                      o_in_stall;
    logic signed [DELTA_W-1:0] i_depth_delta;
    logic [CODE_W-1:0]         i_base_code;
    logic                      i_contig_end;
    logic                      i_report;
    logic                      o_out_valid;
    logic                      i_out_stall;
    logic [IDX_W-1:0]          o_counter_index;
    logic [CNT_W-1:0]          o_counter_value;
    logic                      o_last_counter;
    logic                      i_cfg_we;
    logic [CAP_W-1:0]          i_cfg_wdata;

    depth_tally tracker = new();
    int gap_pct   = 0;
    int stall_pct = 0;
    int quiet     = 0;

    coverage_depth_histogram_core DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_depth_delta   (i_depth_delta),
        .i_base_code     (i_base_code),
        .i_contig_end    (i_contig_end),
        .i_report        (i_report),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_counter_index (o_counter_index),
        .o_counter_value (o_counter_value),
        .o_last_counter  (o_last_counter),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        i_out_stall <= (stall_pct != 0) && ($urandom_range(0, 99) < stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            tracker.check_counter(o_counter_index, o_counter_value, o_last_counter);
        end
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet = 0;
        end else begin
            quiet++;
        end
        if (quiet >= QUIET_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
            $display("coverage_depth_histogram_core_test: done, errors");
            $finish;
        end
    end

    task automatic set_idling(input int mode);
        case (mode)
            0: begin gap_pct = 0;  stall_pct = 0;  end
            1: begin gap_pct = 66; stall_pct = 0;  end
            2: begin gap_pct = 0;  stall_pct = 66; end
            default: begin gap_pct = 29; stall_pct = 29; end
        endcase
    endtask

    task automatic send_request(input t_position_req r);
        while ($urandom_range(0, 99) < gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_depth_delta <= r.delta;
        i_base_code   <= r.code;
        i_contig_end  <= r.contig_end;
        i_report      <= r.report;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        tracker.note_request(r);
    endtask

    task automatic send_position(input int delta, input int code, input bit last);
        t_position_req r;
        r.delta      = DELTA_W'(delta);
        r.code       = CODE_W'(code);
        r.contig_end = last;
        r.report     = 1'b0;
        send_request(r);
    endtask

    task automatic send_report();
        t_position_req r;
        r.delta      = DELTA_W'($urandom_range(0, 65535));
        r.code       = CODE_W'($urandom_range(0, 15));
        r.contig_end = 1'($urandom_range(0, 1));
        r.report     = 1'b1;
        send_request(r);
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (tracker.pending() != 0) @(posedge i_clk);
    endtask

    task automatic write_cap(input logic [CAP_W-1:0] value);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        tracker.cap = value;
    endtask

    function automatic t_position_req random_request();
        t_position_req r;
        int            pick;
        int            d;
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
            d = int'($urandom_range(0, 20)) - 8;
        end else if (pick < 85) begin
            d = int'($urandom_range(0, 65535));
        end else if (pick < 92) begin
            d = 32767 - int'($urandom_range(0, 3));
        end else begin
            d = -32768 + int'($urandom_range(0, 3));
        end
        r.delta      = d[DELTA_W-1:0];
        r.code       = ($urandom_range(0, 4) == 0) ? N_CODE : CODE_W'($urandom_range(0, 14));
        r.contig_end = ($urandom_range(0, 11) == 0);
        r.report     = ($urandom_range(0, 9) == 0);
        return r;
    endfunction

    logic [CAP_W-1:0] cap_plan [6];

    initial begin
        i_rst_n       <= 1'b0;
        i_in_valid    <= 1'b0;
        i_depth_delta <= '0;
        i_base_code   <= '0;
        i_contig_end  <= 1'b0;
        i_report      <= 1'b0;
        i_out_stall   <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_wdata   <= '0;
        cap_plan = '{24'd0, 24'hFFFFFF, 24'd40, CAP_W'($urandom_range(1, 16777214)),
                     24'd1, CAP_RESET};
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        set_idling(0);
        send_report();
        send_position(1, 0, 0);
        send_position(4, 1, 0);
        send_position(5, 2, 0);
        send_position(5, 3, 0);
        send_position(5, 4, 0);
        send_position(5, 8, 0);
        send_position(5, 14, 0);
        send_position(9, 7, 0);
        send_position(1, 6, 0);
        send_position(32767, 5, 0);
        send_position(0, 15, 0);
        send_position(-32768, 9, 0);
        send_position(-32768, 10, 0);
        send_position(-1, 15, 0);
        send_position(300, 11, 1);
        send_position(0, 12, 0);
        send_report();
        send_position(7, 15, 1);
        send_position(2, 13, 0);
        send_report();

        for (int p = 0; p < 6; p++) begin
            write_cap(cap_plan[p]);
            set_idling(p % 4);
            if (cap_plan[p] == 24'hFFFFFF) begin
                for (int k = 0; k < CLIMB_ITEMS; k++) begin
                    send_position(32767, $urandom_range(0, 14), 0);
                end
                send_report();
                send_position(32767, 15, 0);
                send_position(-32768, 3, 0);
                send_position(5, 2, 1);
                send_report();
            end
            for (int k = 0; k < RANDOM_ITEMS; k++) begin
                if (k % 8 == 0) set_idling((p + k / 8) % 4);
                send_request(random_request());
            end
            send_report();
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (tracker.errors == 0 && tracker.pending() == 0) begin
            $display("coverage_depth_histogram_core_test: done, clean");
        end else begin
            $display("coverage_depth_histogram_core_test: done, errors");
        end
        $finish;
    end

endmodule

// ===== coverage_depth_histogram_core.f =====
src/cdh_pkg.sv
src/cdh_counters.sv
src/coverage_depth_histogram_core.sv
test/coverage_depth_histogram_core_test.sv
